/* rtl/ctb_pkg.sv */
package ctb_pkg;

    localparam int KEY_IN_BITS = 16;
    localparam int IDX_BITS    = 6;
    localparam int S_DATA_BITS = 16;
    localparam int M_DATA_BITS = 32;

    typedef struct packed {
        logic init;
        logic set_ovf;
        logic walk_step;
        logic link_root;
        logic link_right;
        logic link_fix;
        logic inc_count;
        logic dump_read;
        logic dump_load;
        logic dump_clear;
    } ctb_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_continue;
        logic new_root;
        logic rc_valid;
        logic out_free;
        logic dump_last;
    } ctb_stat_t;

endpackage

/* rtl/ctb_ram.sv */
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ctb_datapath.sv */
module ctb_datapath #(
    parameter int MAX_NODES = 64,
    parameter int KEY_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ctb_pkg::ctb_cmd_t                   cmd,
    output ctb_pkg::ctb_stat_t                  stat,
    input  logic [ctb_pkg::KEY_IN_BITS-1:0]     key_in,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [ctb_pkg::M_DATA_BITS-1:0]     m_tdata,
    output logic                                m_tlast
);
    import ctb_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LW = AW + 1;
    localparam int KW = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] root_reg, root_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [KW-1:0] key_reg, key_next;
    logic [AW-1:0] rc_reg, rc_next;

    logic                   m_valid_reg, m_valid_next;
    logic [M_DATA_BITS-1:0] m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    logic [AW-1:0] idx_new;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] key_rd;
    logic [LW-1:0] par_rd, left_rd, right_rd;

    logic          key_we, par_we, left_we, right_we;
    logic [AW-1:0] par_wa, left_wa, right_wa;
    logic [LW-1:0] par_wd, left_wd, right_wd;
    logic [KW-1:0] key_wd;
    logic          key_le;

    logic [IDX_BITS-1:0] par_idx, left_idx, right_idx;

    assign idx_new = count_reg[AW-1:0];
    assign key_wd  = key_in[KW-1:0];

    // shared read port address for all four stores
    always_comb begin
        priority if (cmd.dump_read) begin
            rd_addr = j_reg;
        end else if (cmd.init) begin
            rd_addr = idx_new - AW'(1);
        end else if (cmd.walk_step) begin
            rd_addr = par_rd[AW-1:0];
        end else begin
            rd_addr = cur_reg;
        end
    end

    always_comb begin
        key_we   = cmd.init;
        par_we   = 1'b0;
        par_wa   = idx_new;
        par_wd   = '0;
        left_we  = 1'b0;
        left_wa  = idx_new;
        left_wd  = '0;
        right_we = 1'b0;
        right_wa = idx_new;
        right_wd = '0;
        priority if (cmd.init) begin
            par_we   = 1'b1;
            left_we  = 1'b1;
            right_we = 1'b1;
        end else if (cmd.link_root) begin
            par_we  = 1'b1;
            par_wa  = root_reg;
            par_wd  = {1'b1, idx_new};
            left_we = 1'b1;
            left_wd = {1'b1, root_reg};
        end else if (cmd.link_right) begin
            par_we   = 1'b1;
            par_wd   = {1'b1, cur_reg};
            left_we  = right_rd[AW];
            left_wd  = right_rd;
            right_we = 1'b1;
            right_wa = cur_reg;
            right_wd = {1'b1, idx_new};
        end else if (cmd.link_fix) begin
            par_we = 1'b1;
            par_wa = rc_reg;
            par_wd = {1'b1, idx_new};
        end else begin
            par_we = 1'b0;
        end
    end

    ctb_ram #(.WIDTH(KW), .DEPTH(MAX_NODES)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (idx_new),
        .wr_data (key_wd),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    ctb_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_par_ram (
        .aclk    (aclk),
        .wr_en   (par_we),
        .wr_addr (par_wa),
        .wr_data (par_wd),
        .rd_addr (rd_addr),
        .rd_data (par_rd)
    );

    ctb_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_left_ram (
        .aclk    (aclk),
        .wr_en   (left_we),
        .wr_addr (left_wa),
        .wr_data (left_wd),
        .rd_addr (rd_addr),
        .rd_data (left_rd)
    );

    ctb_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_right_ram (
        .aclk    (aclk),
        .wr_en   (right_we),
        .wr_addr (right_wa),
        .wr_data (right_wd),
        .rd_addr (rd_addr),
        .rd_data (right_rd)
    );

    assign key_le = (key_rd <= key_reg);

    assign par_idx   = par_rd[AW]   ? IDX_BITS'(par_rd[AW-1:0])   : '0;
    assign left_idx  = left_rd[AW]  ? IDX_BITS'(left_rd[AW-1:0])  : '0;
    assign right_idx = right_rd[AW] ? IDX_BITS'(right_rd[AW-1:0]) : '0;

    always_comb begin
        count_next   = count_reg;
        root_next    = root_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        cur_next     = cur_reg;
        key_next     = key_reg;
        rc_next      = rc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (cmd.init) begin
            key_next = key_wd;
            cur_next = idx_new - AW'(1);
        end
        if (cmd.walk_step) begin
            cur_next = par_rd[AW-1:0];
        end
        if (cmd.link_root) begin
            root_next = idx_new;
        end
        if (cmd.link_right) begin
            rc_next = right_rd[AW-1:0];
        end
        if (cmd.inc_count) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_ovf) begin
            ovf_next = 1'b1;
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.dump_load) begin
            m_valid_next = 1'b1;
            m_data_next  = M_DATA_BITS'({ovf_reg,
                                         right_rd[AW], right_idx,
                                         left_rd[AW], left_idx,
                                         par_rd[AW], par_idx,
                                         IDX_BITS'(j_reg)});
            m_last_next  = stat.dump_last;
            j_next       = j_reg + AW'(1);
        end
        if (cmd.dump_clear) begin
            count_next = '0;
            root_next  = '0;
            ovf_next   = 1'b0;
            j_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            root_reg    <= '0;
            ovf_reg     <= 1'b0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            root_reg    <= root_next;
            ovf_reg     <= ovf_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        key_reg    <= key_next;
        rc_reg     <= rc_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign stat.full          = (count_reg == CW'(MAX_NODES));
    assign stat.empty         = (count_reg == '0);
    assign stat.walk_continue = (cur_reg != root_reg) && key_le;
    assign stat.new_root      = (cur_reg == root_reg) && key_le;
    assign stat.rc_valid      = right_rd[AW];
    assign stat.out_free      = !m_valid_reg || m_tready;
    assign stat.dump_last     = ((CW'(j_reg) + CW'(1)) == count_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/ctb_ctrl.sv */
module ctb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output ctb_pkg::ctb_cmd_t   cmd,
    input  ctb_pkg::ctb_stat_t  stat
);
    import ctb_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_WALK      = 3'd1;
    localparam logic [2:0] ST_FIX       = 3'd2;
    localparam logic [2:0] ST_DUMP_ADDR = 3'd3;
    localparam logic [2:0] ST_DUMP_LOAD = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       eos_reg, eos_next;
    logic [2:0] done_state;

    assign s_tready   = (state_reg == ST_IDLE);
    assign done_state = eos_reg ? ST_DUMP_ADDR : ST_IDLE;

    always_comb begin
        state_next = state_reg;
        eos_next   = eos_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    eos_next = s_tlast;
                    priority if (stat.full) begin
                        cmd.set_ovf = 1'b1;
                        state_next  = s_tlast ? ST_DUMP_ADDR : ST_IDLE;
                    end else if (stat.empty) begin
                        cmd.init      = 1'b1;
                        cmd.inc_count = 1'b1;
                        state_next    = s_tlast ? ST_DUMP_ADDR : ST_IDLE;
                    end else begin
                        cmd.init   = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                priority if (stat.walk_continue) begin
                    cmd.walk_step = 1'b1;
                end else if (stat.new_root) begin
                    cmd.link_root = 1'b1;
                    cmd.inc_count = 1'b1;
                    state_next    = done_state;
                end else begin
                    cmd.link_right = 1'b1;
                    if (stat.rc_valid) begin
                        state_next = ST_FIX;
                    end else begin
                        cmd.inc_count = 1'b1;
                        state_next    = done_state;
                    end
                end
            end
            ST_FIX: begin
                cmd.link_fix  = 1'b1;
                cmd.inc_count = 1'b1;
                state_next    = done_state;
            end
            ST_DUMP_ADDR: begin
                cmd.dump_read = 1'b1;
                state_next    = ST_DUMP_LOAD;
            end
            ST_DUMP_LOAD: begin
                cmd.dump_read = 1'b1;
                if (stat.out_free) begin
                    cmd.dump_load = 1'b1;
                    if (stat.dump_last) begin
                        cmd.dump_clear = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_DUMP_ADDR;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            eos_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            eos_reg   <= eos_next;
        end
    end

endmodule

/* rtl/cartesian_tree_builder.sv */
// channel   dir   tdata                      tlast             tuser
// s_        in    key                        end of sequence   -
// m_        out   node record with links     last record       -
//
// the first key is written in the idle state; later keys are written, then climb the
// right spine and are linked, with a fix step when a right child is re-hung; the climb
// reads the stores through one shared registered read port, one node a cycle
// each dump record passes an address state and a load state; the load waits while a record is held and m_tready is low
// reset clears count, root, overflow, dump index, output valid and control state only; the stores need no clearing pass
// s_tready is high only while no key is being placed and no dump is running
module cartesian_tree_builder #(
    parameter int MAX_NODES = 64,
    parameter int KEY_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ctb_pkg::S_DATA_BITS-1:0]     s_tdata,  // key[15:0]
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // node_index[5:0], parent_index[11:6], has_parent[12], left_index[18:13],
    // has_left[19], right_index[25:20], has_right[26], overflowed[27], zero[31:28]
    output logic [ctb_pkg::M_DATA_BITS-1:0]     m_tdata,
    output logic                                m_tlast
);
    import ctb_pkg::*;

    ctb_cmd_t  cmd;
    ctb_stat_t stat;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ctb_datapath #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .key_in   (s_tdata[KEY_IN_BITS-1:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
